// File: rtl/core/rde_pkg.sv
`default_nettype none
package rde_pkg;

  localparam int VALUE_W       = 32;
  localparam int RADIX_W       = 5;
  localparam int DIGIT_W       = 4;
  localparam int CHAR_W        = 8;
  localparam int OUT_CHAR_W    = 7;
  localparam int ALPHA_CHARS   = 16;
  localparam int ALPHA_W       = ALPHA_CHARS * CHAR_W;
  localparam int DIGIT_DEPTH   = 32;
  localparam int COUNT_W       = $clog2(DIGIT_DEPTH + 1);
  localparam int STEP_BITS     = 4;
  localparam int STEP_CNT      = VALUE_W / STEP_BITS;
  localparam int STEP_CNT_W    = $clog2(STEP_CNT);
  localparam int MAX_RADIX_DEF = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_W         = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HI = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_MIN   = 8'd33;
  localparam logic [CHAR_W-1:0] CHAR_MAX   = 8'd126;

  typedef struct packed {
    logic done;
    logic ok;
  } chk_status_t;

  function automatic logic [CHAR_W-1:0] alpha_char(input logic [ALPHA_W-1:0] alpha,
                                                   input logic [DIGIT_W-1:0] k);
    return alpha[k * CHAR_W +: CHAR_W];
  endfunction

  function automatic logic char_bad(input logic [CHAR_W-1:0] c);
    return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_SPACE) ||
           (c < CHAR_MIN) || (c > CHAR_MAX);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rde_alpha_check.sv
`default_nettype none
module rde_alpha_check #(
  parameter int MAX_RADIX = rde_pkg::MAX_RADIX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rde_pkg::RADIX_W-1:0] radix_size,
  input  wire logic [rde_pkg::ALPHA_W-1:0] alphabet,
  output rde_pkg::chk_status_t             status
);
  import rde_pkg::*;

  localparam int IDX_W = (MAX_RADIX > 1) ? $clog2(MAX_RADIX) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RADIX - 1);

  logic             busy_r;
  logic             done_r;
  logic             bad_r;
  logic [IDX_W-1:0] idx_r;
  logic             step_bad;
  logic             size_bad;

  assign size_bad = (radix_size < RADIX_W'(2)) || (radix_size > RADIX_W'(MAX_RADIX));

  // one character a cycle, compared against every later character at once
  always_comb begin
    logic [DIGIT_W-1:0] i4;
    logic [CHAR_W-1:0]  c;
    i4       = DIGIT_W'(idx_r);
    c        = alpha_char(alphabet, i4);
    step_bad = 1'b0;
    if ({1'b0, i4} < radix_size) begin
      if (char_bad(c)) step_bad = 1'b1;
      for (int j = 0; j < ALPHA_CHARS; j++) begin
        if ((RADIX_W'(j) > {1'b0, i4}) && (RADIX_W'(j) < radix_size) &&
            (alpha_char(alphabet, DIGIT_W'(j)) == c)) begin
          step_bad = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bad_r  <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
        bad_r  <= size_bad;
      end else if (busy_r) begin
        bad_r <= bad_r | step_bad;
        if (idx_r == LAST_IDX) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r + 1'b1;
        end
      end
    end
  end

  assign status.done = done_r;
  assign status.ok   = !bad_r;

endmodule
`default_nettype wire

// File: rtl/core/rde_div_serial.sv
`default_nettype none
module rde_div_serial (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rde_pkg::VALUE_W-1:0] dividend,
  input  wire logic [rde_pkg::RADIX_W-1:0] radix,
  output logic                             done,
  output logic [rde_pkg::VALUE_W-1:0]      quotient,
  output logic [rde_pkg::DIGIT_W-1:0]      remainder
);
  import rde_pkg::*;

  localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(STEP_CNT - 1);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [VALUE_W-1:0]    quo_r;
  logic [VALUE_W-1:0]    quo_nxt;
  logic [DIGIT_W-1:0]    rem_r;
  logic [DIGIT_W-1:0]    rem_nxt;

  // restoring division, STEP_BITS dividend bits per cycle; quotient bits shift in low
  always_comb begin
    logic [DIGIT_W:0] t;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    for (int k = 0; k < STEP_BITS; k++) begin
      t       = {rem_nxt, quo_nxt[VALUE_W-1]};
      quo_nxt = {quo_nxt[VALUE_W-2:0], 1'b0};
      if (t >= radix) begin
        t          = t - radix;
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = t[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// File: rtl/core/rde_digit_stack.sv
`default_nettype none
module rde_digit_stack (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic                        pop,
  input  wire logic [rde_pkg::DIGIT_W-1:0] din,
  output logic [rde_pkg::DIGIT_W-1:0]      top,
  output logic [rde_pkg::COUNT_W-1:0]      count
);
  import rde_pkg::*;

  localparam int STACK_W = DIGIT_DEPTH * DIGIT_W;

  logic [STACK_W-1:0] stack_r;
  logic [COUNT_W-1:0] count_r;

  // push shifts up from the low end, pop shifts back down
  always_ff @(posedge clk) begin
    if (push) begin
      stack_r <= {stack_r[STACK_W-DIGIT_W-1:0], din};
    end else if (pop) begin
      stack_r <= {DIGIT_W'(0), stack_r[STACK_W-1:DIGIT_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (push) begin
      count_r <= count_r + 1'b1;
    end else if (pop) begin
      count_r <= count_r - 1'b1;
    end
  end

  assign top   = stack_r[DIGIT_W-1:0];
  assign count = count_r;

endmodule
`default_nettype wire

// File: rtl/core/radix_digit_emitter_core.sv
// Flow: an accepted request first goes through the alphabet check; if that passes, it
// goes through the serial divider once per digit (4 dividend bits a cycle), D digits in all.
// The first character is then registered, followed by one character per cycle while
// out_ready holds high ('-' first when negative).
// Requests are taken one at a time: a new one is accepted only when idle.
// Reset (rst_n low, synchronous) clears the sequencer, output valid and config registers.
`default_nettype none
module radix_digit_emitter_core #(
  parameter int MAX_RADIX = rde_pkg::MAX_RADIX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rde_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rde_pkg::CFG_W-1:0]      cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [rde_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rde_pkg::OUT_CHAR_W-1:0]      out_char_code,
  output logic                                out_is_last
);
  import rde_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]            state_r;
  logic [1:0]            state_nxt;
  logic [RADIX_W-1:0]    radix_size_r;
  logic [CFG_W-1:0]      alphabet_low_r;
  logic [CFG_W-1:0]      alphabet_high_r;
  logic [ALPHA_W-1:0]    alphabet;
  logic                  neg_r;
  logic [VALUE_W-1:0]    mag_r;
  logic [VALUE_W-1:0]    in_u;
  logic [VALUE_W-1:0]    in_mag;
  logic                  in_acc;
  chk_status_t           chk;
  logic                  div_start;
  logic [VALUE_W-1:0]    div_dividend;
  logic                  div_done;
  logic [VALUE_W-1:0]    div_quo;
  logic [DIGIT_W-1:0]    div_rem;
  logic                  stk_push;
  logic                  stk_pop;
  logic [DIGIT_W-1:0]    stk_top;
  logic [COUNT_W-1:0]    stk_count;
  logic [CHAR_W-1:0]     digit_char;
  logic                  out_load;
  logic                  out_valid_r;
  logic [OUT_CHAR_W-1:0] out_char_code_r;
  logic                  out_is_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_size_r    <= '0;
      alphabet_low_r  <= '0;
      alphabet_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RADIX:    radix_size_r    <= cfg_wdata[RADIX_W-1:0];
        CFG_ALPHA_LO: alphabet_low_r  <= cfg_wdata;
        CFG_ALPHA_HI: alphabet_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign alphabet = {alphabet_high_r, alphabet_low_r};

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_u     = in_value;
  // unsigned magnitude, so the most negative value stays correct
  assign in_mag   = in_u[VALUE_W-1] ? (~in_u + 1'b1) : in_u;

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign stk_push = (state_r == ST_DIV) && div_done;
  assign stk_pop  = out_load && !neg_r;

  assign div_start = ((state_r == ST_CHECK) && chk.done && chk.ok) ||
                     ((state_r == ST_DIV) && div_done && (div_quo != '0));
  assign div_dividend = (state_r == ST_CHECK) ? mag_r : div_quo;

  rde_alpha_check #(
    .MAX_RADIX(MAX_RADIX)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .radix_size(radix_size_r),
    .alphabet  (alphabet),
    .status    (chk)
  );

  rde_div_serial u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (radix_size_r),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  rde_digit_stack u_stack (
    .clk  (clk),
    .rst_n(rst_n),
    .push (stk_push),
    .pop  (stk_pop),
    .din  (div_rem),
    .top  (stk_top),
    .count(stk_count)
  );

  assign digit_char = alpha_char(alphabet, stk_top);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_CHECK;
      ST_CHECK: if (chk.done) state_nxt = chk.ok ? ST_DIV : ST_IDLE;
      ST_DIV:   if (div_done && (div_quo == '0)) state_nxt = ST_EMIT;
      ST_EMIT:  if (stk_pop && (stk_count == COUNT_W'(1))) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        neg_r <= in_u[VALUE_W-1];
      end else if (out_load) begin
        // sign goes out first, then drop the flag
        neg_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mag_r <= in_mag;
    end
    if (out_load) begin
      out_char_code_r <= neg_r ? CHAR_MINUS[OUT_CHAR_W-1:0] : digit_char[OUT_CHAR_W-1:0];
      out_is_last_r   <= !neg_r && (stk_count == COUNT_W'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_code_r;
  assign out_is_last   = out_is_last_r;

endmodule
`default_nettype wire
